// File: rtl/mwdm_pkg.sv
`default_nettype none

package mwdm_pkg;

    // width of one speed field of a motion command
    localparam int SPEED_W = 12;

    // wheel lanes
    localparam int WHEELS   = 4;
    localparam int WHEEL_FL = 0;
    localparam int WHEEL_FR = 1;
    localparam int WHEEL_RL = 2;
    localparam int WHEEL_RR = 3;

endpackage

`default_nettype wire

// File: rtl/mwdm_cmd_if.sv
`default_nettype none

interface mwdm_cmd_if
    import mwdm_pkg::*;
;
    logic                      valid;
    logic                      ready;
    logic signed [SPEED_W-1:0] speed_x;
    logic signed [SPEED_W-1:0] speed_y;
    logic signed [SPEED_W-1:0] speed_rot;

    modport source (
        output valid,
        output speed_x,
        output speed_y,
        output speed_rot,
        input  ready
    );

    modport sink (
        input  valid,
        input  speed_x,
        input  speed_y,
        input  speed_rot,
        output ready
    );
endinterface

`default_nettype wire

// File: rtl/mwdm_duty_if.sv
`default_nettype none

interface mwdm_duty_if #(
    parameter int DUTY_BITS = 10
);
    logic                 valid;
    logic                 ready;
    logic [DUTY_BITS-1:0] front_left_duty;
    logic                 front_left_fwd;
    logic [DUTY_BITS-1:0] front_right_duty;
    logic                 front_right_fwd;
    logic [DUTY_BITS-1:0] rear_left_duty;
    logic                 rear_left_fwd;
    logic [DUTY_BITS-1:0] rear_right_duty;
    logic                 rear_right_fwd;

    modport source (
        output valid,
        output front_left_duty,
        output front_left_fwd,
        output front_right_duty,
        output front_right_fwd,
        output rear_left_duty,
        output rear_left_fwd,
        output rear_right_duty,
        output rear_right_fwd,
        input  ready
    );

    modport sink (
        input  valid,
        input  front_left_duty,
        input  front_left_fwd,
        input  front_right_duty,
        input  front_right_fwd,
        input  rear_left_duty,
        input  rear_left_fwd,
        input  rear_right_duty,
        input  rear_right_fwd,
        output ready
    );
endinterface

`default_nettype wire

// File: rtl/mwdm_mix.sv
`default_nettype none

// front end: clamp and wheel sums, magnitudes and normaliser, scaled dividends
module mwdm_mix
    import mwdm_pkg::*;
#(
    parameter int DUTY_BITS       = 10,
    parameter int SPEED_FRAC_BITS = 10,
    parameter int SPD_W           = 12,
    parameter int SUM_W           = 14,
    parameter int MAG_W           = 13
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic signed [SPEED_W-1:0]         in_x,
    input  logic signed [SPEED_W-1:0]         in_y,
    input  logic signed [SPEED_W-1:0]         in_rot,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [WHEELS-1:0][MAG_W-1:0]      out_rem,
    output logic [WHEELS-1:0][DUTY_BITS-1:0]  out_bits,
    output logic [MAG_W-1:0]                  out_n,
    output logic [WHEELS-1:0]                 out_fwd
);

    localparam int D_W = MAG_W + DUTY_BITS;
    localparam logic signed [SPD_W-1:0] S_ONE = $signed(SPD_W'(1) << SPEED_FRAC_BITS);
    localparam logic [MAG_W-1:0]        M_ONE = MAG_W'(1) << SPEED_FRAC_BITS;

    // stage valid bits and handshake
    logic v1_reg, v2_reg, v3_reg;
    logic v1_next, v2_next, v3_next;
    logic rdy1, rdy2, rdy3;

    // stage payloads
    logic [WHEELS-1:0][SUM_W-1:0]     sum_reg, sum_next;
    logic [WHEELS-1:0][MAG_W-1:0]     mag_reg, mag_next;
    logic [WHEELS-1:0]                pos_reg, pos_next;
    logic [MAG_W-1:0]                 n2_reg, n2_next;
    logic [WHEELS-1:0][MAG_W-1:0]     rem_reg, rem_next;
    logic [WHEELS-1:0][DUTY_BITS-1:0] low_reg, low_next;
    logic [MAG_W-1:0]                 n3_reg, n3_next;
    logic [WHEELS-1:0]                fwd_reg, fwd_next;

    // a stage takes a new request when empty or when its contents move on
    assign rdy3     = !v3_reg || out_ready;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    assign v1_next = rdy1 ? in_valid : v1_reg;
    assign v2_next = rdy2 ? v1_reg   : v2_reg;
    assign v3_next = rdy3 ? v2_reg   : v3_reg;

    // stage 1: saturate speeds and form the wheel sums
    always_comb
    begin
        logic signed [SPD_W-1:0] sx, sy, sr;
        logic signed [SUM_W-1:0] x, y, r;
        sx = SPD_W'(in_x);
        sy = SPD_W'(in_y);
        sr = SPD_W'(in_rot);
        if (sx > S_ONE) sx = S_ONE;
        else if (sx < -S_ONE) sx = -S_ONE;
        if (sy > S_ONE) sy = S_ONE;
        else if (sy < -S_ONE) sy = -S_ONE;
        if (sr > S_ONE) sr = S_ONE;
        else if (sr < -S_ONE) sr = -S_ONE;
        x = SUM_W'(sx);
        y = SUM_W'(sy);
        r = SUM_W'(sr);
        sum_next[WHEEL_FL] = x - y - r;
        sum_next[WHEEL_FR] = x + y + r;
        sum_next[WHEEL_RL] = x + y - r;
        sum_next[WHEEL_RR] = x - y + r;
    end

    // stage 2: magnitudes, direction and the normaliser
    always_comb
    begin
        logic signed [SUM_W-1:0] s;
        logic [SUM_W-1:0]        m;
        n2_next = M_ONE;
        for (int i = 0; i < WHEELS; i++)
        begin
            s = $signed(sum_reg[i]);
            m = s[SUM_W-1] ? SUM_W'(-s) : SUM_W'(s);
            mag_next[i] = m[MAG_W-1:0];
            pos_next[i] = !s[SUM_W-1] && (s != '0);
            if (m[MAG_W-1:0] > n2_next)
                n2_next = m[MAG_W-1:0];
        end
    end

    // stage 3: numerator times the full-scale duty, split for the divider
    always_comb
    begin
        logic [MAG_W-1:0] num;
        logic [D_W-1:0]   d;
        for (int i = 0; i < WHEELS; i++)
        begin
            num = pos_reg[i] ? n2_reg - mag_reg[i] : mag_reg[i];
            d = {num, {DUTY_BITS{1'b0}}} - D_W'(num);
            rem_next[i] = d[D_W-1:DUTY_BITS];
            low_next[i] = d[DUTY_BITS-1:0];
        end
        n3_next  = n2_reg;
        fwd_next = pos_reg;
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (rdy1 && in_valid)
            sum_reg <= sum_next;
        if (rdy2 && v1_reg)
        begin
            mag_reg <= mag_next;
            pos_reg <= pos_next;
            n2_reg  <= n2_next;
        end
        if (rdy3 && v2_reg)
        begin
            rem_reg <= rem_next;
            low_reg <= low_next;
            n3_reg  <= n3_next;
            fwd_reg <= fwd_next;
        end
    end

    assign out_valid = v3_reg;
    assign out_rem   = rem_reg;
    assign out_bits  = low_reg;
    assign out_n     = n3_reg;
    assign out_fwd   = fwd_reg;

endmodule

`default_nettype wire

// File: rtl/mwdm_div_stage.sv
`default_nettype none

// one restoring division step for all four wheels; quotient bits shift in
// behind the dividend bits they replace
module mwdm_div_stage
    import mwdm_pkg::*;
#(
    parameter int DUTY_BITS = 10,
    parameter int MAG_W     = 13
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [WHEELS-1:0][MAG_W-1:0]     in_rem,
    input  logic [WHEELS-1:0][DUTY_BITS-1:0] in_bits,
    input  logic [MAG_W-1:0]                 in_n,
    input  logic [WHEELS-1:0]                in_fwd,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [WHEELS-1:0][MAG_W-1:0]     out_rem,
    output logic [WHEELS-1:0][DUTY_BITS-1:0] out_bits,
    output logic [MAG_W-1:0]                 out_n,
    output logic [WHEELS-1:0]                out_fwd
);

    logic                             valid_reg, valid_next;
    logic [WHEELS-1:0][MAG_W-1:0]     rem_reg, rem_next;
    logic [WHEELS-1:0][DUTY_BITS-1:0] bits_reg, bits_next;
    logic [MAG_W-1:0]                 n_reg, n_next;
    logic [WHEELS-1:0]                fwd_reg, fwd_next;

    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    // trial subtract of the normaliser from the shifted remainder
    always_comb
    begin
        logic [MAG_W:0] t;
        logic [MAG_W:0] diff;
        logic           ge;
        for (int i = 0; i < WHEELS; i++)
        begin
            t    = {in_rem[i], in_bits[i][DUTY_BITS-1]};
            diff = t - {1'b0, in_n};
            ge   = (t >= {1'b0, in_n});
            rem_next[i]  = ge ? diff[MAG_W-1:0] : t[MAG_W-1:0];
            bits_next[i] = {in_bits[i][DUTY_BITS-2:0], ge};
        end
        n_next   = in_n;
        fwd_next = in_fwd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            rem_reg  <= rem_next;
            bits_reg <= bits_next;
            n_reg    <= n_next;
            fwd_reg  <= fwd_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_bits  = bits_reg;
    assign out_n     = n_reg;
    assign out_fwd   = fwd_reg;

endmodule

`default_nettype wire

// File: rtl/mecanum_wheel_duty_mixer.sv
`default_nettype none

// channel | role   | request contents
// --------+--------+------------------------------------------------------
// cmd     | sink   | speed_x, speed_y, speed_rot (signed, 1/2^frac units)
// duty    | source | duty and forward bit for each of the four wheels
//
// one request per cycle unless the duty sink stalls; the pipe has
// three front-end stages, then one restoring division step per duty bit
// reset clears only the stage valid bits
// each stage holds while it is full and the next one cannot take it;
// bubbles close up, so cmd.ready is high whenever duty.ready is high
module mecanum_wheel_duty_mixer
    import mwdm_pkg::*;
#(
    parameter int DUTY_BITS       = 10,
    parameter int SPEED_FRAC_BITS = 10
) (
    input  logic         clk,
    input  logic         rst_n,
    mwdm_cmd_if.sink     cmd,
    mwdm_duty_if.source  duty
);

    localparam int SPD_W = (SPEED_FRAC_BITS + 2 > SPEED_W) ? SPEED_FRAC_BITS + 2 : SPEED_W;
    localparam int SUM_W = SPD_W + 2;
    localparam int MAG_W = SUM_W - 1;

    // divider chain, index 0 fed by the front end
    logic                             valid_c [DUTY_BITS+1];
    logic                             ready_c [DUTY_BITS+1];
    logic [WHEELS-1:0][MAG_W-1:0]     rem_c   [DUTY_BITS+1];
    logic [WHEELS-1:0][DUTY_BITS-1:0] bits_c  [DUTY_BITS+1];
    logic [MAG_W-1:0]                 n_c     [DUTY_BITS+1];
    logic [WHEELS-1:0]                fwd_c   [DUTY_BITS+1];

    mwdm_mix #(
        .DUTY_BITS       (DUTY_BITS),
        .SPEED_FRAC_BITS (SPEED_FRAC_BITS),
        .SPD_W           (SPD_W),
        .SUM_W           (SUM_W),
        .MAG_W           (MAG_W)
    ) u_mix (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cmd.valid),
        .in_ready  (cmd.ready),
        .in_x      (cmd.speed_x),
        .in_y      (cmd.speed_y),
        .in_rot    (cmd.speed_rot),
        .out_valid (valid_c[0]),
        .out_ready (ready_c[0]),
        .out_rem   (rem_c[0]),
        .out_bits  (bits_c[0]),
        .out_n     (n_c[0]),
        .out_fwd   (fwd_c[0])
    );

    // one quotient bit per stage
    for (genvar k = 0; k < DUTY_BITS; k++)
    begin : g_div
        mwdm_div_stage #(
            .DUTY_BITS (DUTY_BITS),
            .MAG_W     (MAG_W)
        ) u_div (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (valid_c[k]),
            .in_ready  (ready_c[k]),
            .in_rem    (rem_c[k]),
            .in_bits   (bits_c[k]),
            .in_n      (n_c[k]),
            .in_fwd    (fwd_c[k]),
            .out_valid (valid_c[k+1]),
            .out_ready (ready_c[k+1]),
            .out_rem   (rem_c[k+1]),
            .out_bits  (bits_c[k+1]),
            .out_n     (n_c[k+1]),
            .out_fwd   (fwd_c[k+1])
        );
    end

    // result side: last divider stage is the output register
    assign duty.valid            = valid_c[DUTY_BITS];
    assign ready_c[DUTY_BITS]    = duty.ready;
    assign duty.front_left_duty  = bits_c[DUTY_BITS][WHEEL_FL];
    assign duty.front_left_fwd   = fwd_c[DUTY_BITS][WHEEL_FL];
    assign duty.front_right_duty = bits_c[DUTY_BITS][WHEEL_FR];
    assign duty.front_right_fwd  = fwd_c[DUTY_BITS][WHEEL_FR];
    assign duty.rear_left_duty   = bits_c[DUTY_BITS][WHEEL_RL];
    assign duty.rear_left_fwd    = fwd_c[DUTY_BITS][WHEEL_RL];
    assign duty.rear_right_duty  = bits_c[DUTY_BITS][WHEEL_RR];
    assign duty.rear_right_fwd   = fwd_c[DUTY_BITS][WHEEL_RR];

    // a ready sink lets the whole pipe move, so the command side is ready too
    a_ready_through: assert property (@(posedge clk) disable iff (!rst_n)
        duty.ready |-> cmd.ready)
        else $error("cmd not ready while duty sink is ready");

    // the upper dividend part is below the normaliser, so the quotient fits
    a_quot_fits: assert property (@(posedge clk) disable iff (!rst_n)
        valid_c[0] |-> (rem_c[0][WHEEL_FL] < n_c[0]) && (rem_c[0][WHEEL_FR] < n_c[0])
                    && (rem_c[0][WHEEL_RL] < n_c[0]) && (rem_c[0][WHEEL_RR] < n_c[0]))
        else $error("dividend too large for duty width");

    // final remainders stay below the normaliser
    a_rem_final: assert property (@(posedge clk) disable iff (!rst_n)
        duty.valid |-> (rem_c[DUTY_BITS][WHEEL_FL] < n_c[DUTY_BITS])
                    && (rem_c[DUTY_BITS][WHEEL_FR] < n_c[DUTY_BITS])
                    && (rem_c[DUTY_BITS][WHEEL_RL] < n_c[DUTY_BITS])
                    && (rem_c[DUTY_BITS][WHEEL_RR] < n_c[DUTY_BITS]))
        else $error("divider remainder out of range");

endmodule

`default_nettype wire

// File: tb/mecanum_wheel_duty_mixer_tb.sv
`timescale 1ns / 100ps

module mecanum_wheel_duty_mixer_tb
    import mwdm_pkg::*;
;

    localparam int DUTY_BITS       = 10;
    localparam int SPEED_FRAC_BITS = 10;
    localparam int SPEED_ONE       = 1 << SPEED_FRAC_BITS;
    localparam int DUTY_FULL       = (1 << DUTY_BITS) - 1;
    localparam int PIPE_DEPTH      = DUTY_BITS + 3;
    localparam int STALL_LIMIT     = 2000;
    localparam int RANDOM_PER_PHASE = 263;
    localparam int PRINT_LIMIT     = 100;

    typedef struct packed {
        logic signed [SPEED_W-1:0] x;
        logic signed [SPEED_W-1:0] y;
        logic signed [SPEED_W-1:0] rot;
    } motion_cmd_t;

    typedef struct packed {
        logic [WHEELS-1:0][DUTY_BITS-1:0] duty;
        logic [WHEELS-1:0]                fwd;
    } wheel_drive_t;

    typedef struct packed {
        motion_cmd_t  cmd;
        wheel_drive_t drive;
    } drive_expect_t;

    logic clk;
    logic rst_n;

    mwdm_cmd_if                          cmd_bus ();
    mwdm_duty_if #(.DUTY_BITS(DUTY_BITS)) duty_bus ();

    mecanum_wheel_duty_mixer #(
        .DUTY_BITS       (DUTY_BITS),
        .SPEED_FRAC_BITS (SPEED_FRAC_BITS)
    ) uut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_bus),
        .duty  (duty_bus)
    );

    motion_cmd_t   pending_cmds [$];
    drive_expect_t expected_drives [$];
    logic          cmd_taken = 1'b0;
    int            send_idle_pct = 0;
    int            stall_pct = 0;
    int            mismatch_count = 0;
    int            idle_cycles = 0;
    string         wheel_names [WHEELS];

    // clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // saturate a raw speed to +-one
    function automatic int saturate_speed(logic signed [SPEED_W-1:0] raw);
        int v;
        v = raw;
        if (v > SPEED_ONE)
            v = SPEED_ONE;
        else if (v < -SPEED_ONE)
            v = -SPEED_ONE;
        return v;
    endfunction

    // wheel sums, normaliser and per-wheel duty and direction
    function automatic wheel_drive_t mix_wheels(motion_cmd_t c);
        int x;
        int y;
        int r;
        int norm;
        int mag;
        int num;
        int sums [WHEELS];
        wheel_drive_t d;
        x = saturate_speed(c.x);
        y = saturate_speed(c.y);
        r = saturate_speed(c.rot);
        sums[WHEEL_FL] = x - y - r;
        sums[WHEEL_FR] = x + y + r;
        sums[WHEEL_RL] = x + y - r;
        sums[WHEEL_RR] = x - y + r;
        norm = SPEED_ONE;
        for (int i = 0; i < WHEELS; i++)
        begin
            mag = (sums[i] < 0) ? -sums[i] : sums[i];
            if (mag > norm)
                norm = mag;
        end
        for (int i = 0; i < WHEELS; i++)
        begin
            // forward wheels get the inverted duty
            if (sums[i] > 0)
            begin
                d.fwd[i] = 1'b1;
                num = norm - sums[i];
            end
            else
            begin
                d.fwd[i] = 1'b0;
                num = -sums[i];
            end
            d.duty[i] = DUTY_BITS'((num * DUTY_FULL) / norm);
        end
        return d;
    endfunction

    task automatic report_mismatch(string msg);
        if (mismatch_count < PRINT_LIMIT)
            $display("%0t mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic add_cmd(int x, int y, int rot);
        motion_cmd_t c;
        c.x   = SPEED_W'(x);
        c.y   = SPEED_W'(y);
        c.rot = SPEED_W'(rot);
        pending_cmds.push_back(c);
    endtask

    // mostly in range, some raw 12-bit values, some extremes
    function automatic int random_speed();
        int pick;
        pick = $urandom_range(99);
        if (pick < 70)
            return int'($urandom_range(2 * SPEED_ONE)) - SPEED_ONE;
        else if (pick < 85)
            return $urandom;
        case ($urandom_range(4))
            0: return SPEED_ONE;
            1: return -SPEED_ONE;
            2: return 0;
            3: return -2048;
            default: return 2047;
        endcase
    endfunction

    // hold the sender until every request has come back
    task automatic drain_results();
        while (pending_cmds.size() != 0 || cmd_bus.valid || expected_drives.size() != 0)
            @(negedge clk);
    endtask

    task automatic run_phase(int idle_pct, int stall);
        send_idle_pct = idle_pct;
        stall_pct     = stall;
        for (int i = 0; i < RANDOM_PER_PHASE; i++)
            add_cmd(random_speed(), random_speed(), random_speed());
        drain_results();
    endtask

    // request driver
    always @(negedge clk)
    begin
        motion_cmd_t next_cmd;
        if (rst_n && (!cmd_bus.valid || cmd_taken))
        begin
            if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                next_cmd = pending_cmds.pop_front();
                cmd_bus.valid     <= 1'b1;
                cmd_bus.speed_x   <= next_cmd.x;
                cmd_bus.speed_y   <= next_cmd.y;
                cmd_bus.speed_rot <= next_cmd.rot;
            end
            else
                cmd_bus.valid <= 1'b0;
        end
    end

    // result receiver stalls
    always @(negedge clk)
    begin
        duty_bus.ready <= ($urandom_range(99) >= stall_pct);
    end

    // monitor: predict on accepted commands, check accepted results
    always @(posedge clk)
    begin
        motion_cmd_t   seen_cmd;
        drive_expect_t want;
        if (rst_n)
        begin
            cmd_taken <= cmd_bus.valid && cmd_bus.ready;
            if (cmd_bus.valid && cmd_bus.ready)
            begin
                seen_cmd.x   = cmd_bus.speed_x;
                seen_cmd.y   = cmd_bus.speed_y;
                seen_cmd.rot = cmd_bus.speed_rot;
                want.cmd     = seen_cmd;
                want.drive   = mix_wheels(seen_cmd);
                expected_drives.push_back(want);
            end
            if (duty_bus.valid && duty_bus.ready)
            begin
                if (expected_drives.size() == 0)
                    report_mismatch("result with no command outstanding");
                else
                begin
                    want = expected_drives.pop_front();
                    for (int i = 0; i < WHEELS; i++)
                    begin
                        logic [DUTY_BITS-1:0] got_duty;
                        logic                 got_fwd;
                        case (i)
                            WHEEL_FL:
                            begin
                                got_duty = duty_bus.front_left_duty;
                                got_fwd  = duty_bus.front_left_fwd;
                            end
                            WHEEL_FR:
                            begin
                                got_duty = duty_bus.front_right_duty;
                                got_fwd  = duty_bus.front_right_fwd;
                            end
                            WHEEL_RL:
                            begin
                                got_duty = duty_bus.rear_left_duty;
                                got_fwd  = duty_bus.rear_left_fwd;
                            end
                            default:
                            begin
                                got_duty = duty_bus.rear_right_duty;
                                got_fwd  = duty_bus.rear_right_fwd;
                            end
                        endcase
                        if (got_duty !== want.drive.duty[i])
                            report_mismatch($sformatf(
                                "%s_duty got %0d expected %0d (x %0d y %0d rot %0d)",
                                wheel_names[i], got_duty, want.drive.duty[i],
                                want.cmd.x, want.cmd.y, want.cmd.rot));
                        if (got_fwd !== want.drive.fwd[i])
                            report_mismatch($sformatf(
                                "%s_fwd got %0b expected %0b (x %0d y %0d rot %0d)",
                                wheel_names[i], got_fwd, want.drive.fwd[i],
                                want.cmd.x, want.cmd.y, want.cmd.rot));
                    end
                end
            end
        end
    end

    // watchdog on cycles with work outstanding and no handshake
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((cmd_bus.valid && cmd_bus.ready) || (duty_bus.valid && duty_bus.ready))
                idle_cycles <= 0;
            else if (pending_cmds.size() != 0 || expected_drives.size() != 0 || cmd_bus.valid)
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("[mecanum_wheel_duty_mixer] ERROR");
                $finish;
            end
        end
    end

    // stimulus and end of run
    initial
    begin
        wheel_names[WHEEL_FL] = "front_left";
        wheel_names[WHEEL_FR] = "front_right";
        wheel_names[WHEEL_RL] = "rear_left";
        wheel_names[WHEEL_RR] = "rear_right";
        rst_n             = 1'b0;
        cmd_bus.valid     = 1'b0;
        cmd_bus.speed_x   = '0;
        cmd_bus.speed_y   = '0;
        cmd_bus.speed_rot = '0;
        duty_bus.ready    = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: zero, single axes at full scale, saturation, zero sums,
        // largest wheel forward and backward
        add_cmd(0, 0, 0);
        add_cmd(SPEED_ONE, 0, 0);
        add_cmd(-SPEED_ONE, 0, 0);
        add_cmd(0, SPEED_ONE, 0);
        add_cmd(0, -SPEED_ONE, 0);
        add_cmd(0, 0, SPEED_ONE);
        add_cmd(0, 0, -SPEED_ONE);
        add_cmd(SPEED_ONE, SPEED_ONE, SPEED_ONE);
        add_cmd(-SPEED_ONE, -SPEED_ONE, -SPEED_ONE);
        add_cmd(SPEED_ONE, -SPEED_ONE, -SPEED_ONE);
        add_cmd(2047, -2048, 2047);
        add_cmd(-2048, 2047, -2048);
        add_cmd(2047, 2047, 2047);
        add_cmd(-2048, -2048, -2048);
        add_cmd(SPEED_ONE + 1, -SPEED_ONE - 1, 0);
        add_cmd(SPEED_ONE / 2, SPEED_ONE / 2, 0);
        add_cmd(1, 0, 0);
        add_cmd(-1, 0, 0);
        add_cmd(SPEED_ONE - 1, 1, -1);
        drain_results();

        // random phases with different idling
        run_phase(0, 0);
        run_phase(75, 0);
        run_phase(0, 75);
        run_phase(9, 9);

        repeat (PIPE_DEPTH + 10) @(posedge clk);
        if (mismatch_count == 0)
            $display("[mecanum_wheel_duty_mixer] OK");
        else
            $display("[mecanum_wheel_duty_mixer] ERROR");
        $finish;
    end

endmodule
